### hw/rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants of the cosine similarity engine
// Field widths, step counts, the controller command set and the status word.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int ELEM_W = 16;
    localparam int SIM_W  = 17;
    localparam int DOT_W  = 40;
    localparam int NORM_W = 39;
    localparam int IDX_W  = 6;

    localparam int MUL_STEPS  = 40;
    localparam int DIV_STEPS  = 34;
    localparam int SQRT_STEPS = 17;

    localparam logic [SIM_W-1:0] SIM_ONE = 17'h10000;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACC,
        CMD_LOAD_NN,
        CMD_MUL,
        CMD_LOAD_DD,
        CMD_LOAD_DIV,
        CMD_DIV,
        CMD_SQRT,
        CMD_FINISH
    } cse_op_t;

    typedef struct packed {
        cse_op_t          op;
        logic [IDX_W-1:0] idx;
    } cse_cmd_t;

    typedef struct packed {
        logic zero_norm;
    } cse_status_t;

endpackage

### hw/rtl/cse_if.sv
// ----------------------------------------------------------------------------
// cse_if: stream channels of the cosine similarity engine
// One channel carries element pairs, the other carries results.
// ----------------------------------------------------------------------------
interface cse_pair_if;
    logic                                valid;
    logic                                ready;
    logic signed [cse_pkg::ELEM_W-1:0]   elem_a;
    logic signed [cse_pkg::ELEM_W-1:0]   elem_b;
    logic                                last_elem;

    modport source (output valid, elem_a, elem_b, last_elem, input ready);
    modport sink (input valid, elem_a, elem_b, last_elem, output ready);
endinterface

interface cse_result_if;
    logic                          valid;
    logic                          ready;
    logic [cse_pkg::SIM_W-1:0]     similarity;
    logic                          zero_norm;
    logic                          length_exceeded;

    modport source (output valid, similarity, zero_norm, length_exceeded, input ready);
    modport sink (input valid, similarity, zero_norm, length_exceeded, output ready);
endinterface

### hw/rtl/cse_dp.sv
// ----------------------------------------------------------------------------
// cse_dp: datapath of the cosine similarity engine
// Accumulators, a shift-add multiplier, a restoring divider, a square root
// search and the result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module cse_dp #(
    parameter int MAX_LEN = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cse_pkg::cse_cmd_t                   cmd,
    input  logic signed [cse_pkg::ELEM_W-1:0]   elem_a,
    input  logic signed [cse_pkg::ELEM_W-1:0]   elem_b,
    output cse_pkg::cse_status_t                status,
    output logic [cse_pkg::SIM_W-1:0]           similarity,
    output logic                                zero_norm,
    output logic                                length_exceeded
);
    import cse_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int PROD_W = 2 * DOT_W;
    localparam int NN_W = 2 * NORM_W;

    logic signed [DOT_W-1:0]  dot_reg, dot_next;
    logic [NORM_W-1:0]        na_reg, na_next;
    logic [NORM_W-1:0]        nb_reg, nb_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;
    logic [PROD_W-1:0]        mc_reg, mc_next;
    logic [DOT_W-1:0]         mp_reg, mp_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [NN_W-1:0]          nn_reg, nn_next;
    logic [1:0]               rr_reg, rr_next;
    logic [NN_W-1:0]          rem_reg, rem_next;
    logic [DIV_STEPS-1:0]     q_reg, q_next;
    logic                     big_reg, big_next;
    logic [SIM_W-1:0]         s_reg, s_next;
    logic [SIM_W-1:0]         sim_reg, sim_next;
    logic                     zero_reg, zero_next;
    logic                     len_reg, len_next;

    logic signed [2*ELEM_W-1:0] p_ab;
    logic signed [2*ELEM_W-1:0] p_aa;
    logic signed [2*ELEM_W-1:0] p_bb;
    logic signed [DOT_W:0]      dot_sum;
    logic [NORM_W:0]            na_sum;
    logic [NORM_W:0]            nb_sum;
    logic [DOT_W-1:0]           dot_mag;
    logic [NN_W-1:0]            rr_shift;
    logic                       div_bit;
    logic [NN_W:0]              div_sh;
    logic                       div_geq;
    logic [SIM_W-1:0]           try_s;
    logic [2*SIM_W-1:0]         try_sq;
    logic                       is_zero;

    always_comb
    begin
        p_ab = elem_a * elem_b;
        p_aa = elem_a * elem_a;
        p_bb = elem_b * elem_b;
        dot_sum = {dot_reg[DOT_W-1], dot_reg} + (DOT_W+1)'(p_ab);
        na_sum = {1'b0, na_reg} + (NORM_W+1)'($unsigned(p_aa));
        nb_sum = {1'b0, nb_reg} + (NORM_W+1)'($unsigned(p_bb));
        dot_mag = dot_reg[DOT_W-1] ? (DOT_W)'(-dot_reg) : $unsigned(dot_reg);
        rr_shift = prod_reg[PROD_W-1:2];
        div_bit = (cmd.idx == IDX_W'(DIV_STEPS - 1)) ? rr_reg[1] :
                  (cmd.idx == IDX_W'(DIV_STEPS - 2)) ? rr_reg[0] : 1'b0;
        div_sh = {rem_reg, div_bit};
        div_geq = (div_sh >= {1'b0, nn_reg});
        try_s = s_reg | (SIM_W'(1) << cmd.idx[4:0]);
        try_sq = try_s * try_s;
        is_zero = (na_reg == '0) || (nb_reg == '0);
    end

    always_comb
    begin
        dot_next = dot_reg;
        na_next = na_reg;
        nb_next = nb_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        mc_next = mc_reg;
        mp_next = mp_reg;
        prod_next = prod_reg;
        nn_next = nn_reg;
        rr_next = rr_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        big_next = big_reg;
        s_next = s_reg;
        sim_next = sim_reg;
        zero_next = zero_reg;
        len_next = len_reg;
        unique case (cmd.op)
            CMD_ACC:
            begin
                if (cnt_reg < CNT_W'(MAX_LEN))
                begin
                    if (dot_sum[DOT_W] != dot_sum[DOT_W-1])
                    begin
                        dot_next = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                                  : {1'b0, {(DOT_W-1){1'b1}}};
                    end
                    else
                    begin
                        dot_next = dot_sum[DOT_W-1:0];
                    end
                    na_next = na_sum[NORM_W] ? '1 : na_sum[NORM_W-1:0];
                    nb_next = nb_sum[NORM_W] ? '1 : nb_sum[NORM_W-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            CMD_LOAD_NN:
            begin
                mc_next = PROD_W'(na_reg);
                mp_next = DOT_W'(nb_reg);
                prod_next = '0;
            end
            CMD_MUL:
            begin
                if (mp_reg[0])
                begin
                    prod_next = prod_reg + mc_reg;
                end
                mc_next = {mc_reg[PROD_W-2:0], 1'b0};
                mp_next = {1'b0, mp_reg[DOT_W-1:1]};
            end
            CMD_LOAD_DD:
            begin
                nn_next = prod_reg[NN_W-1:0];
                mc_next = PROD_W'(dot_mag);
                mp_next = dot_mag;
                prod_next = '0;
            end
            CMD_LOAD_DIV:
            begin
                rr_next = prod_reg[1:0];
                rem_next = rr_shift;
                big_next = ({2'b00, rr_shift} >= {2'b00, nn_reg}) || (prod_reg[PROD_W-1:PROD_W-2] != 2'b00);
                q_next = '0;
                s_next = '0;
            end
            CMD_DIV:
            begin
                rem_next = div_geq ? NN_W'(div_sh - {1'b0, nn_reg}) : div_sh[NN_W-1:0];
                q_next = {q_reg[DIV_STEPS-2:0], div_geq};
            end
            CMD_SQRT:
            begin
                if (try_sq <= q_reg)
                begin
                    s_next = try_s;
                end
            end
            CMD_FINISH:
            begin
                if (is_zero)
                begin
                    sim_next = '0;
                end
                else if (big_reg || (s_reg > SIM_ONE))
                begin
                    sim_next = SIM_ONE;
                end
                else
                begin
                    sim_next = s_reg;
                end
                zero_next = is_zero;
                len_next = ovf_reg;
                dot_next = '0;
                na_next = '0;
                nb_next = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg <= '0;
            nb_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            dot_reg <= dot_next;
            na_reg <= na_next;
            nb_reg <= nb_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg <= mc_next;
        mp_reg <= mp_next;
        prod_reg <= prod_next;
        nn_reg <= nn_next;
        rr_reg <= rr_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        big_reg <= big_next;
        s_reg <= s_next;
        sim_reg <= sim_next;
        zero_reg <= zero_next;
        len_reg <= len_next;
    end

    assign status.zero_norm = is_zero;
    assign similarity = sim_reg;
    assign zero_norm = zero_reg;
    assign length_exceeded = len_reg;

endmodule

### hw/rtl/cse_ctrl.sv
// ----------------------------------------------------------------------------
// cse_ctrl: controller of the cosine similarity engine
// Sequences accumulation, the final multiplies, divide and square root steps,
// and holds the result valid flag.
// ----------------------------------------------------------------------------
module cse_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  cse_pkg::cse_status_t   status,
    output cse_pkg::cse_cmd_t      cmd
);
    import cse_pkg::*;

    typedef enum logic [3:0] {
        S_ACC,
        S_CHECK,
        S_MUL_NN,
        S_LD_DD,
        S_MUL_DD,
        S_LD_DIV,
        S_DIV,
        S_SQRT,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             ov_reg, ov_next;
    logic             slot_free;

    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        ov_next = ov_reg && !out_ready;
        cmd.op = CMD_NONE;
        cmd.idx = idx_reg;
        unique case (state_reg)
            S_ACC:
            begin
                if (in_valid)
                begin
                    cmd.op = CMD_ACC;
                    if (in_last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (status.zero_norm)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = CMD_LOAD_NN;
                    idx_next = IDX_W'(MUL_STEPS - 1);
                    state_next = S_MUL_NN;
                end
            end
            S_MUL_NN:
            begin
                cmd.op = CMD_MUL;
                idx_next = idx_reg - IDX_W'(1);
                if (idx_reg == '0)
                begin
                    state_next = S_LD_DD;
                end
            end
            S_LD_DD:
            begin
                cmd.op = CMD_LOAD_DD;
                idx_next = IDX_W'(MUL_STEPS - 1);
                state_next = S_MUL_DD;
            end
            S_MUL_DD:
            begin
                cmd.op = CMD_MUL;
                idx_next = idx_reg - IDX_W'(1);
                if (idx_reg == '0)
                begin
                    state_next = S_LD_DIV;
                end
            end
            S_LD_DIV:
            begin
                cmd.op = CMD_LOAD_DIV;
                idx_next = IDX_W'(DIV_STEPS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = CMD_DIV;
                idx_next = idx_reg - IDX_W'(1);
                if (idx_reg == '0)
                begin
                    idx_next = IDX_W'(SQRT_STEPS - 1);
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op = CMD_SQRT;
                idx_next = idx_reg - IDX_W'(1);
                if (idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.op = CMD_FINISH;
                    ov_next = 1'b1;
                    state_next = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            idx_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            ov_reg <= ov_next;
        end
    end

    assign in_ready = (state_reg == S_ACC);
    assign out_valid = ov_reg;

endmodule

### hw/rtl/cosine_similarity_engine.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine: streaming absolute cosine similarity
// Accumulates dot product and norms over element pairs and reports
// |dot| / sqrt(normA * normB) as unsigned Q1.16 after the last pair.
// ----------------------------------------------------------------------------
// A pair word is taken whenever one is offered while the block is accumulating.
// After the word marked last, two 40-step shift-add multiplications, a 34-step
// restoring division and a 17-step square root search run on one shared
// datapath, and no pair is taken until the result is in the output register.
// A zero norm skips that work and goes straight from the norm check to the
// final step. The output register lets the next vector stream in while the
// previous result waits to be taken; if that result is still waiting when
// the next one is ready, the final step waits until it is read.
module cosine_similarity_engine #(
    parameter int MAX_LEN = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cse_pair_if.sink              pairs,
    cse_result_if.source          result
);
    import cse_pkg::*;

    cse_cmd_t    cmd;
    cse_status_t status;

    cse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pairs.valid),
        .in_last   (pairs.last_elem),
        .in_ready  (pairs.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cse_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .elem_a          (pairs.elem_a),
        .elem_b          (pairs.elem_b),
        .status          (status),
        .similarity      (result.similarity),
        .zero_norm       (result.zero_norm),
        .length_exceeded (result.length_exceeded)
    );

endmodule
